// ----- design/rgb_box_blur_5x5_core_defines.svh -----
// assertion macros shared by the checker of rgb_box_blur_5x5_core
// expects i_clk and i_rst_n in the scope of use
`ifndef RGB_BOX_BLUR_5X5_CORE_DEFINES_SVH
`define RGB_BOX_BLUR_5X5_CORE_DEFINES_SVH

// step property, disabled while reset is low
`define RBB_ASSERT_STEP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbb check failed");

// state seen on the cycle after reset
`define RBB_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("rbb reset check failed");

`endif

// ----- design/rbb_pkg.sv -----
// shared types and constants of the box blur block
// no dependencies
package rbb_pkg;

    localparam int COL_W  = 11;
    localparam int ROW_W  = 16;
    localparam int RING_W = 4;
    localparam int LAG_W  = 14;
    localparam int IDX_W  = 1;
    localparam int CFG_W  = 16;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [RING_W-1:0] ring;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [RING_W-1:0] ring;
        logic [COL_W-1:0]  col;
        logic [23:0]       pix;
    } t_mem_wr;

    typedef struct packed {
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
    } t_geom;

endpackage

// ----- design/rbb_front.sv -----
// front end: accepts items, tracks input and output positions, issues jobs
// depends on rbb_pkg
module rbb_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rbb_pkg::t_in_item           i_in_data,
    input  logic                        i_cfg_we,
    input  logic [rbb_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [rbb_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_q_busy,
    input  logic                        i_back_reading,
    output logic                        o_push,
    output rbb_pkg::t_job               o_job,
    output rbb_pkg::t_mem_wr            o_wr,
    output rbb_pkg::t_geom              o_geom
);
    import rbb_pkg::*;

    localparam int RING = 3 * RADIUS + 1;

    logic [COL_W-1:0]  r_cfg_w;
    logic [ROW_W-1:0]  r_cfg_h;
    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [RING_W-1:0] r_in_ring;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [RING_W-1:0] r_out_ring;
    logic [LAG_W-1:0]  r_lead;

    logic [COL_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [LAG_W-1:0] lag;
    logic [LAG_W-1:0] lead_inc;
    logic             accept;
    logic             full;
    logic             pixel_take;
    logic             emit;
    logic             last;

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = COL_W'(1);
        end else if (LAG_W'(r_cfg_w) > LAG_W'(MAX_WIDTH)) begin
            eff_w = COL_W'(MAX_WIDTH);
        end else begin
            eff_w = r_cfg_w;
        end
        eff_h      = (r_cfg_h == '0) ? ROW_W'(1) : r_cfg_h;
        lag        = LAG_W'(RADIUS) * LAG_W'(eff_w) + LAG_W'(RADIUS);
        lead_inc   = r_lead + LAG_W'(1);
        o_in_ready = !i_q_busy && !i_back_reading;
        accept     = i_in_valid && o_in_ready;
        full       = (r_in_row == eff_h);
        pixel_take = accept && !full && (i_in_data.op == OP_PIXEL);
        emit       = accept && (full || (pixel_take && (lead_inc > lag)));
        last       = (r_out_row == eff_h - ROW_W'(1)) && (r_out_col == eff_w - COL_W'(1));
    end

    assign o_push      = emit;
    assign o_job.ring  = r_out_ring;
    assign o_job.row   = r_out_row;
    assign o_job.col   = r_out_col;
    assign o_job.last  = last;
    assign o_wr.en     = pixel_take;
    assign o_wr.ring   = r_in_ring;
    assign o_wr.col    = r_in_col;
    assign o_wr.pix    = {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
    assign o_geom.width  = eff_w;
    assign o_geom.height = eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= COL_W'(1);
            r_cfg_h    <= ROW_W'(1);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_ring  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_ring <= '0;
            r_lead     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data[COL_W-1:0];
                REG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data[ROW_W-1:0];
                default:          r_cfg_w <= r_cfg_w;
            endcase
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_ring  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_ring <= '0;
            r_lead     <= '0;
        end else begin
            if (pixel_take) begin
                if (r_in_col == eff_w - COL_W'(1)) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + ROW_W'(1);
                    r_in_ring <= (r_in_ring == RING_W'(RING - 1)) ? '0 : r_in_ring + RING_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
                if (!(lead_inc > lag)) begin
                    r_lead <= lead_inc;
                end
            end
            if (emit) begin
                if (last) begin
                    // frame done, every position back to the start
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_ring  <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_ring <= '0;
                    r_lead     <= '0;
                end else if (r_out_col == eff_w - COL_W'(1)) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + ROW_W'(1);
                    r_out_ring <= (r_out_ring == RING_W'(RING - 1)) ? '0
                                : r_out_ring + RING_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

endmodule

// ----- design/rbb_queue.sv -----
// two-entry job queue between front and back
// depends on rbb_pkg
module rbb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbb_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_head_valid,
    output rbb_pkg::t_job o_head
);
    import rbb_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- design/rbb_back.sv -----
// back end: row store, window sum over cycles, serial divide, output register
// depends on rbb_pkg
module rbb_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbb_pkg::t_mem_wr   i_wr,
    input  rbb_pkg::t_geom     i_geom,
    input  logic               i_head_valid,
    input  rbb_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_reading,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rbb_pkg::t_out_item o_out_data
);
    import rbb_pkg::*;

    localparam int RING   = 3 * RADIUS + 1;
    localparam int SPAN   = 2 * RADIUS + 1;
    localparam int NWIN   = SPAN * SPAN;
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = $clog2(NWIN * 255 + 1);
    localparam int CNT_W  = $clog2(NWIN + 1);
    localparam int STEP_W = $clog2(SW + 1);
    localparam int RS_W   = RING_W + 2;
    localparam int OFF_W  = 4;

    typedef enum logic [2:0] {ST_IDLE, ST_SUM, ST_DRAIN, ST_DIV, ST_HOLD} t_state;

    t_state            r_state;
    t_job              r_job;
    logic [OFF_W-1:0]  r_dy;
    logic [OFF_W-1:0]  r_dx;
    logic              r_rd_vld;
    logic [23:0]       r_rd_data;
    logic [SW-1:0]     r_sum [3];
    logic [CNT_W-1:0]  r_rem [3];
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic [23:0] mem [DEPTH];

    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic [RS_W-1:0]  ring_raw;
    logic [RS_W-1:0]  ring_rd;
    logic signed [ROW_W+1:0] win_row;
    logic signed [COL_W+1:0] win_col;
    logic             in_frame;
    logic [CNT_W:0]   div_tmp [3];
    logic             div_ge  [3];

    always_comb begin
        wr_addr  = AW'(i_wr.ring) * AW'(MAX_WIDTH) + AW'(i_wr.col);
        ring_raw = RS_W'(r_job.ring) + RS_W'(RING) + RS_W'(r_dy) - RS_W'(RADIUS);
        // raw slot can pass one or two ring lengths
        ring_rd  = (ring_raw >= RS_W'(2 * RING)) ? ring_raw - RS_W'(2 * RING)
                 : (ring_raw >= RS_W'(RING)) ? ring_raw - RS_W'(RING) : ring_raw;
        win_row  = $signed({2'b00, r_job.row}) + $signed((ROW_W + 2)'(r_dy))
                 - $signed((ROW_W + 2)'(RADIUS));
        win_col  = $signed({2'b00, r_job.col}) + $signed((COL_W + 2)'(r_dx))
                 - $signed((COL_W + 2)'(RADIUS));
        // skip neighbors outside the frame
        in_frame = !win_row[ROW_W+1] && (win_row[ROW_W:0] < {1'b0, i_geom.height})
                && !win_col[COL_W+1] && (win_col[COL_W:0] < {1'b0, i_geom.width});
        rd_en    = (r_state == ST_SUM) && in_frame;
        rd_addr  = AW'(ring_rd) * AW'(MAX_WIDTH) + AW'(win_col[COL_W-1:0]);
        for (int ch = 0; ch < 3; ch++) begin
            div_tmp[ch] = {r_rem[ch], r_sum[ch][SW-1]};
            div_ge[ch]  = (div_tmp[ch] >= {1'b0, r_cnt});
        end
    end

    assign o_pop       = (r_state == ST_IDLE) && i_head_valid;
    assign o_reading   = (r_state == ST_SUM) || (r_state == ST_DRAIN);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[wr_addr] <= i_wr.pix;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (r_out_valid && i_out_ready && (r_state != ST_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            if (r_rd_vld) begin
                r_sum[0] <= r_sum[0] + SW'(r_rd_data[23:16]);
                r_sum[1] <= r_sum[1] + SW'(r_rd_data[15:8]);
                r_sum[2] <= r_sum[2] + SW'(r_rd_data[7:0]);
                r_cnt    <= r_cnt + CNT_W'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_head_valid) begin
                        r_job   <= i_head;
                        r_dy    <= '0;
                        r_dx    <= '0;
                        r_sum[0] <= '0;
                        r_sum[1] <= '0;
                        r_sum[2] <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (r_dx == OFF_W'(SPAN - 1)) begin
                        r_dx <= '0;
                        r_dy <= r_dy + OFF_W'(1);
                        if (r_dy == OFF_W'(SPAN - 1)) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_dx <= r_dx + OFF_W'(1);
                    end
                end
                ST_DRAIN: begin
                    // last read lands in the sums on this edge
                    r_rem[0] <= '0;
                    r_rem[1] <= '0;
                    r_rem[2] <= '0;
                    r_step   <= '0;
                    r_state  <= ST_DIV;
                end
                ST_DIV: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_rem[ch] <= div_ge[ch] ? CNT_W'(div_tmp[ch] - {1'b0, r_cnt})
                                                : div_tmp[ch][CNT_W-1:0];
                        r_sum[ch] <= {r_sum[ch][SW-2:0], div_ge[ch]};
                    end
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SW - 1)) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_data.red_out   <= r_sum[0][7:0];
                        r_out_data.green_out <= r_sum[1][7:0];
                        r_out_data.blue_out  <= r_sum[2][7:0];
                        r_out_data.frame_end <= r_job.last;
                        r_out_valid          <= 1'b1;
                        r_state              <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/rgb_box_blur_5x5_core.sv -----
// streaming box blur, top level; depends on rbb_pkg, rbb_front, rbb_queue, rbb_back
// an item that gives no result is taken while the window unit is not reading and no job waits in the queue
// an item that gives a result holds off the next one until the window unit has taken its job
// and finished the one-read-per-cycle walk of the window over the row store
// result follows the window walk, a drain step, a bit-serial divide over the sum width and the output register
// synchronous active-low reset clears positions and handshakes; row store is not cleared
module rgb_box_blur_5x5_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  rbb_pkg::t_in_item         i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output rbb_pkg::t_out_item        o_out_data,
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic [rbb_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [rbb_pkg::CFG_W-1:0] i_cfg_data
);
    import rbb_pkg::*;

    // front to queue
    logic    push;
    t_job    job;
    // queue to back
    logic    head_valid;
    t_job    head;
    logic    pop;
    // row store writes go straight to the back, which owns the memory
    t_mem_wr wr;
    t_geom   geom;
    // back is walking a window; front must not overwrite the store then
    logic    back_reading;

    rbb_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_busy       (head_valid),
        .i_back_reading (back_reading),
        .o_push         (push),
        .o_job          (job),
        .o_wr           (wr),
        .o_geom         (geom)
    );

    rbb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    rbb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_geom       (geom),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_reading    (back_reading),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- design/rbb_checker.sv -----
// port-level checks on rgb_box_blur_5x5_core, bound to the top level
// depends on rbb_pkg and rgb_box_blur_5x5_core_defines.svh
`include "rgb_box_blur_5x5_core_defines.svh"

module rbb_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rbb_pkg::t_out_item o_out_data
);
    import rbb_pkg::*;

    // a stalled result stays and keeps its value
    `RBB_ASSERT_STEP(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `RBB_ASSERT_STEP(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_data))
    // reset leaves no result pending and the input open
    `RBB_ASSERT_RST(a_rst_no_out, !o_out_valid)
    `RBB_ASSERT_RST(a_rst_ready, o_in_ready)

endmodule

bind rgb_box_blur_5x5_core rbb_port_checker u_rbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- verif/rbb_checker.sv -----
// checker for the box blur block: predicts every blurred pixel and compares transfers
// depends on rbb_pkg; watches the input, result and configuration ports only
`timescale 1ns / 1ps

module rbb_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  rbb_pkg::t_in_item         i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  rbb_pkg::t_out_item        i_out_data,
    input  logic                      i_cfg_we,
    input  logic [rbb_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [rbb_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_results
);
    import rbb_pkg::*;

    localparam int RING = 7;
    localparam int MAXW = 1024;
    localparam int RAD  = 2;

    logic [23:0]   line_mem [RING*MAXW];
    int unsigned   width_reg, height_reg;
    int unsigned   in_col, in_row, out_col, out_row, pix_count;
    t_out_item     expected_pixels [$];

    function automatic int unsigned slot(int unsigned r, int unsigned c);
        return (r % RING) * MAXW + (c % MAXW);
    endfunction

    task automatic restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; pix_count = 0;
    endtask

    // one accepted item: store pixel, maybe emit the window mean
    task automatic blur_predict(t_in_item it);
        int unsigned w, h, total, lag, oidx, sr, sg, sb, cnt;
        int          r, c;
        logic [23:0] px;
        bit          emit;
        t_out_item   res;
        w = (width_reg < 1) ? 1 : (width_reg > MAXW ? MAXW : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        total = w * h;
        lag = RAD * w + RAD;
        oidx = out_row * w + out_col;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        if (pix_count >= total) begin
            emit = 1;
        end else if (it.op == OP_FLUSH) begin
            emit = 0;
        end else begin
            line_mem[slot(in_row, in_col)] = {it.red_in, it.green_in, it.blue_in};
            pix_count++;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            emit = pix_count > oidx + lag;
        end
        if (emit) begin
            for (int dy = -RAD; dy <= RAD; dy++) begin
                r = int'(out_row) + dy;
                if (r < 0 || r >= int'(h)) continue;
                for (int dx = -RAD; dx <= RAD; dx++) begin
                    c = int'(out_col) + dx;
                    if (c < 0 || c >= int'(w)) continue;
                    px = line_mem[slot(r, c)];
                    sr += px[23:16];
                    sg += px[15:8];
                    sb += px[7:0];
                    cnt++;
                end
            end
            res.red_out   = 8'(sr / cnt);
            res.green_out = 8'(sg / cnt);
            res.blue_out  = 8'(sb / cnt);
            res.frame_end = (oidx == total - 1);
            expected_pixels.push_back(res);
            if (oidx == total - 1) begin
                restart_frame();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            width_reg = 1;
            height_reg = 1;
            restart_frame();
            expected_pixels.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAME_WIDTH) width_reg = i_cfg_data & 16'h07FF;
                else if (i_cfg_idx == REG_FRAME_HEIGHT) height_reg = i_cfg_data;
                restart_frame();
            end
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: result mismatch, expected r%h g%h b%h e%b, actual r%h g%h b%h e%b",
                                 $time, want.red_out, want.green_out, want.blue_out,
                                 want.frame_end, i_out_data.red_out, i_out_data.green_out,
                                 i_out_data.blue_out, i_out_data.frame_end);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) blur_predict(i_in_data);
        end
        o_pending <= expected_pixels.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// top of the box blur testbench: clock, reset, stimulus and verdict
// depends on rbb_pkg, rgb_box_blur_5x5_core and rbb_checker
`timescale 1ns / 1ps

module tb_top;
    import rbb_pkg::*;

    localparam int IDLE_LIMIT = 50000;   // cycles without any transfer before giving up

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_data;
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    int errors, pending, results;
    int snd_idle_pct, rcv_idle_pct;
    int items_sent, frames_run;
    int stall_cnt;

    rgb_box_blur_5x5_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    rbb_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // receiver backpressure, rate set per phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // watchdog: any transfer on either channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= IDLE_LIMIT) begin
                $display("rgb_box_blur_5x5_core: mismatch");
                $finish;
            end
        end
    end

    // one input transfer; called and returning on a rising edge
    task automatic push_item(logic op, logic [23:0] px);
        t_in_item it;
        it.op = op;
        {it.red_in, it.green_in, it.blue_in} = px;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // block idle: all results in, then time for a window walk to finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // pixel values lean toward the channel extremes
    function automatic logic [23:0] pick_pixel();
        logic [23:0] px;
        for (int ch = 0; ch < 3; ch++) begin
            case ($urandom_range(3))
                0: px[ch*8 +: 8] = 8'h00;
                1: px[ch*8 +: 8] = 8'hFF;
                default: px[ch*8 +: 8] = 8'($urandom);
            endcase
        end
        return px;
    endfunction

    // full frame then drain; noise adds early flushes and extra items
    task automatic run_frame(logic [CFG_W-1:0] w_val, logic [CFG_W-1:0] h_val,
                             int eff_w, int eff_h, int noise_pct);
        cfg_write(REG_FRAME_WIDTH, w_val);
        cfg_write(REG_FRAME_HEIGHT, h_val);
        for (int i = 0; i < eff_w * eff_h; i++) begin
            if ($urandom_range(99) < noise_pct) push_item(OP_FLUSH, 24'($urandom));
            push_item(OP_PIXEL, pick_pixel());
        end
        // pixels past the frame end act as flushes
        for (int i = 0; i < 2 * eff_w + 2 + $urandom_range(2); i++)
            push_item(1'($urandom), 24'($urandom));
        wait_idle();
        frames_run++;
    endtask

    initial begin
        int w, h;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_data    <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_FRAME_WIDTH;
        i_cfg_data   <= '0;
        i_out_ready  <= 1'b0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        items_sent   = 0;
        frames_run   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset geometry, single pixel frames of both extremes
        push_item(OP_FLUSH, 24'h000000);        // flush with nothing pending
        push_item(OP_PIXEL, 24'hFFFFFF);
        push_item(OP_FLUSH, 24'hFFFFFF);
        push_item(OP_FLUSH, 24'h000000);
        push_item(OP_PIXEL, 24'h000000);
        wait_idle();
        // zero width and height fall back to one
        run_frame(16'h0000, 16'h0000, 1, 1, 0);
        // small square with an early flush in the middle
        cfg_write(REG_FRAME_WIDTH, 16'd3);
        cfg_write(REG_FRAME_HEIGHT, 16'd3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) push_item(OP_FLUSH, 24'hFFFFFF);
            push_item(OP_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
        end
        push_item(OP_PIXEL, 24'h123456);         // past frame end, acts as flush
        for (int i = 0; i < 8; i++) push_item(OP_FLUSH, 24'h0);
        wait_idle();

        // oversize width clamps to the line length, abandoned by the next write
        cfg_write(REG_FRAME_WIDTH, 16'hFFFF);
        cfg_write(REG_FRAME_HEIGHT, 16'd1);
        for (int i = 0; i < 20; i++) push_item(OP_PIXEL, pick_pixel());
        wait_idle();
        // tallest height, abandoned by a restart through the next write
        cfg_write(REG_FRAME_WIDTH, 16'd2);
        cfg_write(REG_FRAME_HEIGHT, 16'hFFFF);
        for (int i = 0; i < 20; i++) push_item(OP_PIXEL, pick_pixel());
        wait_idle();

        // random frames over three backpressure phases
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 66 : 0;
            rcv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 8 : 0;
            while (items_sent < 50 + 250 * (ph + 1)) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                h = $urandom_range(6, 1);
                run_frame(16'(w), 16'(h), w, h, $urandom_range(3) == 0 ? 15 : 0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);

        $display("ran %0d frames, %0d input items, %0d results checked",
                 frames_run, items_sent, results);
        $display("random frames up to 40 wide, zero and oversized geometry, three stall phases");
        if (errors == 0) begin
            $display("rgb_box_blur_5x5_core: match");
        end else begin
            $display("rgb_box_blur_5x5_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/rbb_pkg.sv
design/rbb_front.sv
design/rbb_queue.sv
design/rbb_back.sv
design/rgb_box_blur_5x5_core.sv
design/rbb_checker.sv
verif/rbb_checker.sv
verif/tb_top.sv
